@@ sv/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned PRIO_W = 16;
  localparam int unsigned DATA_W = 32;

  // Priority given to an entry that cuts in at the head
  localparam logic [PRIO_W-1:0] CUTIN_PRIO = 16'd1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CUTIN  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } status_e;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FRONT  = 2'd2,
    CMD_POP    = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_REPORT = 1'b1
  } state_e;

endpackage

@@ sv/spq_cell.sv @@
// One position of the sorted chain: holds a priority and data word.
module spq_cell
  import spq_pkg::*;
(
  input  logic              clk_i,
  input  cmd_t              cmd_i,
  input  logic              valid_i,
  input  logic              left_stay_i,
  input  logic [PRIO_W-1:0] left_prio_i,
  input  logic [DATA_W-1:0] left_data_i,
  input  logic [PRIO_W-1:0] right_prio_i,
  input  logic [DATA_W-1:0] right_data_i,
  output logic              stay_o,
  output logic [PRIO_W-1:0] prio_o,
  output logic [DATA_W-1:0] data_o
);

  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [DATA_W-1:0] data_q, data_d;

  // An occupied entry keeps its place only while every entry ahead of it does too
  // and it is not behind the new one; a cut-in head can break the order
  assign stay_o = (cmd_i.op == CMD_INSERT) && valid_i && left_stay_i &&
                  (prio_q <= cmd_i.prio);

  // Next entry: hold, take the new beat, shift toward tail or toward head
  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    unique case (cmd_i.op)
      CMD_INSERT, CMD_FRONT: begin
        if (!stay_o) begin
          if (left_stay_i) begin
            prio_d = cmd_i.prio;
            data_d = cmd_i.data;
          end else begin
            prio_d = left_prio_i;
            data_d = left_data_i;
          end
        end
      end
      CMD_POP: begin
        prio_d = right_prio_i;
        data_d = right_data_i;
      end
      default: begin
        prio_d = prio_q;
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign prio_o = prio_q;
  assign data_o = data_q;

endmodule

@@ sv/sorted_priority_queue.sv @@
// Sorted priority queue: a chain of DEPTH cells kept in ascending priority order.
// Result path: the chain updates on the accepted input beat, then the report state loads the outputs.
// A new beat is taken only after the report; the cell chain updates in the accept cycle
// and the middle/tail readout muxes load the output register in the next one.
// Reset clears the fill count and handshake state; cell contents are not reset.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       action_i,
  input  logic [PRIO_W-1:0]                priority_req_i,
  input  logic signed [DATA_W-1:0]         payload_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [DATA_W-1:0]         removed_data_o,
  output logic                             removed_valid_o,
  output logic [1:0]                       status_o,
  output logic [$clog2(DEPTH+1)-1:0]       occupancy_o,
  output logic signed [DATA_W-1:0]         middle_data_o,
  output logic signed [DATA_W-1:0]         last_data_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] rem_data_q, rem_data_d;
  logic              rem_valid_q, rem_valid_d;
  status_e           stat_q, stat_d;
  logic [DATA_W-1:0] o_rem_data_q, o_rem_data_d;
  logic              o_rem_valid_q, o_rem_valid_d;
  status_e           o_stat_q, o_stat_d;
  logic [CNT_W-1:0]  o_count_q, o_count_d;
  logic [DATA_W-1:0] o_mid_q, o_mid_d;
  logic [DATA_W-1:0] o_last_q, o_last_d;

  cmd_t              cmd;
  logic              accept;
  logic              full, empty;
  action_e           act;
  logic [CNT_W-1:0]  mid_pos;
  logic [CNT_W-1:0]  last_pos;

  logic [PRIO_W-1:0] cell_prio [DEPTH];
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic              cell_stay [DEPTH];

  assign act    = action_e'(action_i);
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign accept = in_valid_i && in_ready_o;

  // Input taken only while idle and the output slot is free or draining
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  // Command broadcast to the chain, gated by full/empty checks
  always_comb begin
    cmd.op   = CMD_IDLE;
    cmd.prio = priority_req_i;
    cmd.data = payload_i;
    if (accept) begin
      unique case (act)
        ACT_INSERT: if (!full) cmd.op = CMD_INSERT;
        ACT_REMOVE: if (!empty) cmd.op = CMD_POP;
        ACT_CUTIN: begin
          cmd.prio = CUTIN_PRIO;
          if (!full) cmd.op = CMD_FRONT;
        end
        default: cmd.op = CMD_IDLE;
      endcase
    end
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              left_stay;
    logic [PRIO_W-1:0] left_prio, right_prio;
    logic [DATA_W-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_stay = 1'b1;
      assign left_prio = '0;
      assign left_data = '0;
    end else begin : g_body
      assign left_stay = cell_stay[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = '0;
      assign right_data = '0;
    end else begin : g_inner
      assign right_prio = cell_prio[i+1];
      assign right_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .valid_i      (CNT_W'(i) < count_q),
      .left_stay_i  (left_stay),
      .left_prio_i  (left_prio),
      .left_data_i  (left_data),
      .right_prio_i (right_prio),
      .right_data_i (right_data),
      .stay_o       (cell_stay[i]),
      .prio_o       (cell_prio[i]),
      .data_o       (cell_data[i])
    );
  end

  assign mid_pos  = count_q >> 1;
  assign last_pos = count_q - CNT_W'(1);

  // Sequencer: accept a beat, then report the updated chain
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q;
    rem_data_d    = rem_data_q;
    rem_valid_d   = rem_valid_q;
    stat_d        = stat_q;
    o_rem_data_d  = o_rem_data_q;
    o_rem_valid_d = o_rem_valid_q;
    o_stat_d      = o_stat_q;
    o_count_d     = o_count_q;
    o_mid_d       = o_mid_q;
    o_last_d      = o_last_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d     = ST_REPORT;
          rem_data_d  = '0;
          rem_valid_d = 1'b0;
          stat_d      = STAT_OK;
          unique case (cmd.op)
            CMD_INSERT, CMD_FRONT: count_d = count_q + CNT_W'(1);
            CMD_POP: begin
              count_d     = count_q - CNT_W'(1);
              rem_data_d  = cell_data[0];
              rem_valid_d = 1'b1;
            end
            default: begin
              if ((act == ACT_INSERT || act == ACT_CUTIN) && full) stat_d = STAT_FULL;
              else if (act == ACT_REMOVE && empty) stat_d = STAT_EMPTY;
            end
          endcase
        end
      end
      ST_REPORT: begin
        state_d       = ST_IDLE;
        out_valid_d   = 1'b1;
        o_rem_data_d  = rem_data_q;
        o_rem_valid_d = rem_valid_q;
        o_stat_d      = stat_q;
        o_count_d     = count_q;
        if (empty) begin
          o_mid_d  = '0;
          o_last_d = '0;
        end else begin
          o_mid_d  = cell_data[IDX_W'(mid_pos)];
          o_last_d = cell_data[IDX_W'(last_pos)];
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    rem_data_q    <= rem_data_d;
    rem_valid_q   <= rem_valid_d;
    stat_q        <= stat_d;
    o_rem_data_q  <= o_rem_data_d;
    o_rem_valid_q <= o_rem_valid_d;
    o_stat_q      <= o_stat_d;
    o_count_q     <= o_count_d;
    o_mid_q       <= o_mid_d;
    o_last_q      <= o_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign removed_data_o  = o_rem_data_q;
  assign removed_valid_o = o_rem_valid_q;
  assign status_o        = o_stat_q;
  assign occupancy_o     = o_count_q;
  assign middle_data_o   = o_mid_q;
  assign last_data_o     = o_last_q;

  // Fill count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // Output slot is always free when a report is loaded
  a_report_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REPORT |-> !out_valid_q)
    else $error("report would overwrite a pending result");

  // A new result appears only from the report cycle
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_REPORT))
    else $error("result raised outside report");

  // A popped entry is only reported together with a clean status
  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_rem_valid_q |-> o_stat_q == STAT_OK)
    else $error("pop reported with error status");

endmodule
